// File: rtl/hr2d_pkg.sv
// shared constants, payload types and control types of the histogram rank filter
package hr2d_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 15;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WIN_W       = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W       = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

  localparam logic [16:0] Q16_ONE = 17'd65536;

  // opcodes of an input beat
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [7:0] CFG_FRAME_WIDTH   = 8'd0;
  localparam logic [7:0] CFG_FRAME_HEIGHT  = 8'd1;
  localparam logic [7:0] CFG_WINDOW_RADIUS = 8'd2;
  localparam logic [7:0] CFG_RANK_FRACTION = 8'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_BACK,
    ST_PREP,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic push;
    logic setup;
    logic back_step;
    logic scan_init;
    logic scan_step;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic win_done;
    logic back_zero;
    logic thr_zero;
    logic scan_last;
    logic bit_zero;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/hr2d_ram.sv
// generic simple dual port ram with registered read
module hr2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/hr2d_datapath.sv
// datapath: registers, positions, pixel ring, window scan and bitwise rank search
module hr2d_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i,
  input  hr2d_pkg::in_item_t  in_data_i,
  input  hr2d_pkg::cmd_t      cmd_i,
  output hr2d_pkg::status_t   status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hr2d_pkg::out_item_t out_data_o
);
  import hr2d_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  logic [10:0] fw_q;
  logic [12:0] fh_q;
  logic [3:0]  rad_q;
  logic [16:0] rq_q;

  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [3:0]  r_eff;
  logic [16:0] q_eff;

  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic              in_done_q;
  logic              skip_q;
  logic [ADDR_W-1:0] in_addr_q, out_addr_q;

  logic [ADDR_W-1:0] start_q, row_addr_q, scan_addr_q;
  logic [3:0]        back_q;
  logic [WIN_W-1:0]  rows_q, cols_q, row_i_q, col_i_q;
  logic [CNT_W-1:0]  count_q, thr_q, less_q;
  logic [7:0]        res_q;
  logic [2:0]        bit_q;
  logic              rd_vld_q;
  logic [7:0]        rdata;
  logic [7:0]        trial;

  logic [12:0] nr_c, nr_raw;
  logic [10:0] nc_c, nc_raw;
  logic [3:0]  dr, dc;
  logic        last_pos, restart, cfg_hit, store_we;
  logic [26:0] thr_full;

  // modular address helpers
  function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                 input logic [10:0] k);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W + 1)'(k);
    if (s >= (ADDR_W + 1)'(STORE_DEPTH)) s = s - (ADDR_W + 1)'(STORE_DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_sub(input logic [ADDR_W-1:0] a,
                                                 input logic [10:0] k);
    logic [ADDR_W:0] s;
    if ({1'b0, a} >= (ADDR_W + 1)'(k)) s = {1'b0, a} - (ADDR_W + 1)'(k);
    else s = {1'b0, a} + (ADDR_W + 1)'(STORE_DEPTH) - (ADDR_W + 1)'(k);
    return s[ADDR_W-1:0];
  endfunction

  // effective register values after clamping
  always_comb begin
    if (fw_q == '0) w_eff = 11'd1;
    else if (fw_q > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    else w_eff = fw_q;
    if (fh_q == '0) h_eff = 13'd1;
    else if (fh_q > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    else h_eff = fh_q;
    if (rad_q == '0) r_eff = 4'd1;
    else if (rad_q > 4'(MAX_RADIUS)) r_eff = 4'(MAX_RADIUS);
    else r_eff = rad_q;
    q_eff = (rq_q > Q16_ONE) ? Q16_ONE : rq_q;
  end

  // window bounds of the pending output
  always_comb begin
    nr_raw = 13'(out_row_q) + 13'(r_eff);
    nr_c   = (nr_raw > h_eff - 13'd1) ? h_eff - 13'd1 : nr_raw;
    nc_raw = 11'(out_col_q) + 11'(r_eff);
    nc_c   = (nc_raw > w_eff - 11'd1) ? w_eff - 11'd1 : nc_raw;
    dr     = (out_row_q > ROW_W'(r_eff)) ? r_eff : out_row_q[3:0];
    dc     = (out_col_q > COL_W'(r_eff)) ? r_eff : out_col_q[3:0];
    last_pos = (13'(out_row_q) == h_eff - 13'd1) && (11'(out_col_q) == w_eff - 11'd1);
  end

  assign cfg_hit  = cfg_valid_i && (cfg_index_i == CFG_FRAME_WIDTH ||
                    cfg_index_i == CFG_FRAME_HEIGHT || cfg_index_i == CFG_WINDOW_RADIUS ||
                    cfg_index_i == CFG_RANK_FRACTION);
  assign restart  = cfg_hit || (cmd_i.emit && last_pos);
  assign store_we = cmd_i.push && !in_done_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 11'd1024;
      fh_q  <= 13'd1024;
      rad_q <= 4'd1;
      rq_q  <= 17'd32768;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:   fw_q  <= cfg_data_i[10:0];
        CFG_FRAME_HEIGHT:  fh_q  <= cfg_data_i[12:0];
        CFG_WINDOW_RADIUS: rad_q <= cfg_data_i[3:0];
        CFG_RANK_FRACTION: rq_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a push after the last pixel is dropped and sends nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
    end else begin
      skip_q <= cmd_i.push && in_done_q;
    end
  end

  // input and output raster positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_done_q  <= 1'b0;
      in_addr_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_addr_q <= '0;
    end else if (restart) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_done_q  <= 1'b0;
      in_addr_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_addr_q <= '0;
    end else begin
      if (store_we) begin
        in_addr_q <= addr_inc(in_addr_q);
        if (11'(in_col_q) + 11'd1 >= w_eff) begin
          in_col_q <= '0;
          if (13'(in_row_q) + 13'd1 >= h_eff) begin
            in_row_q  <= '0;
            in_done_q <= 1'b1;
          end else begin
            in_row_q <= in_row_q + 1'b1;
          end
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_addr_q <= addr_inc(out_addr_q);
        if (11'(out_col_q) + 11'd1 >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // window setup, walk back to the first row, threshold
  assign thr_full = q_eff * count_q;

  always_ff @(posedge clk_i) begin
    thr_q <= thr_full[16 +: CNT_W];
    if (cmd_i.setup) begin
      start_q <= addr_sub(out_addr_q, 11'(dc));
      back_q  <= dr;
      rows_q  <= WIN_W'(nr_c - 13'(out_row_q)) + WIN_W'(dr) + 1'b1;
      cols_q  <= WIN_W'(nc_c - 11'(out_col_q)) + WIN_W'(dc) + 1'b1;
    end else if (cmd_i.back_step) begin
      start_q <= addr_sub(start_q, w_eff);
      back_q  <= back_q - 1'b1;
    end
    if (cmd_i.setup) begin
      count_q <= CNT_W'(WIN_W'(nr_c - 13'(out_row_q)) + WIN_W'(dr) + 1'b1) *
                 CNT_W'(WIN_W'(nc_c - 11'(out_col_q)) + WIN_W'(dc) + 1'b1);
    end
  end

  // window scan, one stored pixel per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init || cmd_i.decide) begin
      row_addr_q  <= start_q;
      scan_addr_q <= start_q;
      row_i_q     <= '0;
      col_i_q     <= '0;
    end else if (cmd_i.scan_step) begin
      if (col_i_q == cols_q - 1'b1) begin
        col_i_q     <= '0;
        row_i_q     <= row_i_q + 1'b1;
        row_addr_q  <= addr_add(row_addr_q, w_eff);
        scan_addr_q <= addr_add(row_addr_q, w_eff);
      end else begin
        col_i_q     <= col_i_q + 1'b1;
        scan_addr_q <= addr_inc(scan_addr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
    end
  end

  // bitwise search for the smallest level that reaches the threshold
  assign trial = res_q | (8'd1 << bit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init || cmd_i.decide) begin
      less_q <= '0;
    end else if (rd_vld_q && (rdata < trial)) begin
      less_q <= less_q + 1'b1;
    end
    if (cmd_i.scan_init) begin
      res_q <= '0;
      bit_q <= 3'd7;
    end else if (cmd_i.decide) begin
      if (less_q < thr_q) res_q <= trial;
      bit_q <= bit_q - 1'b1;
    end
  end

  hr2d_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(in_addr_q),
    .wdata_i(in_data_i.pixel_in),
    .re_i   (cmd_i.scan_step),
    .raddr_i(scan_addr_q),
    .rdata_o(rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_o.pixel_out <= res_q;
      out_data_o.frame_end <= last_pos;
    end
  end

  // status toward the controller
  always_comb begin
    status_o.win_done  = !skip_q && (in_done_q || (13'(in_row_q) > nr_c) ||
                         ((13'(in_row_q) == nr_c) && (11'(in_col_q) > nc_c)));
    status_o.back_zero = (back_q == '0);
    status_o.thr_zero  = (thr_q == '0);
    status_o.scan_last = (row_i_q == rows_q - 1'b1) && (col_i_q == cols_q - 1'b1);
    status_o.bit_zero  = (bit_q == '0);
    status_o.out_busy  = out_valid_o && !out_ready_i;
  end

endmodule

// File: rtl/hr2d_ctrl.sv
// controller state machine sequencing store, window walk, scans and emit
module hr2d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  hr2d_pkg::status_t status_i,
  output hr2d_pkg::cmd_t    cmd_o
);
  import hr2d_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = status_i.win_done ? ST_SETUP : ST_IDLE;
      ST_SETUP:  state_d = ST_BACK;
      ST_BACK:   if (status_i.back_zero) state_d = ST_PREP;
      ST_PREP:   state_d = status_i.thr_zero ? ST_EMIT : ST_SCAN;
      ST_SCAN:   if (status_i.scan_last) state_d = ST_TAIL;
      ST_TAIL:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = status_i.bit_zero ? ST_EMIT : ST_SCAN;
      ST_EMIT:   if (!status_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.push = in_valid_i && (in_op_i == OP_PUSH);
      end
      ST_SETUP:  cmd_o.setup     = 1'b1;
      ST_BACK:   cmd_o.back_step = !status_i.back_zero;
      ST_PREP:   cmd_o.scan_init = 1'b1;
      ST_SCAN:   cmd_o.scan_step = 1'b1;
      ST_DECIDE: cmd_o.decide    = 1'b1;
      ST_EMIT:   cmd_o.emit      = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: rtl/histogram_rank_filter_2d_core.sv
// top level of the 2d sliding window rank filter
//
// Pixels enter in raster order on the in channel (op push) and results leave
// in raster order on the out channel, one rank statistic per pixel position of
// a square window clipped at the frame edges. A push causes at most one
// result; drain beats flush the results of the frame tail. Pushes after the
// last pixel of a frame are dropped without a result until the frame's last
// result is sent.
// Registers are to be written on the cfg channel only while the block is
// idle, a rule for the user that the block itself does not enforce; a write
// to one of the four registers restarts the frame, keeping stored pixels.
// When a result is due, the block walks back to the first window row (at most
// the radius), then the search runs eight bitwise passes over the clipped
// window, each reading one stored pixel per cycle from the single read port
// of the pixel ring. With a zero threshold the passes are skipped. One beat
// is in work at a time.
// The result sits in an output register; a stalled receiver holds it and the
// block stops only when a new result is ready and the register is still full.
// Reset clears positions and restores default registers; stored pixels are
// undefined until written and no clearing pass is run.
module histogram_rank_filter_2d_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hr2d_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hr2d_pkg::out_item_t out_data_o
);
  import hr2d_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  hr2d_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.op),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  hr2d_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // one beat in work at a time
  a_seq_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted back to back");

  // results are loaded only while no input is taken
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result loaded while idle");

endmodule

// File: test/tb_histogram_rank_filter_2d_core.sv
// testbench of the 2d sliding window rank filter core with a self-checking scoreboard
module tb_histogram_rank_filter_2d_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hr2d_pkg::*;

  // rank filter prediction and result checking
  class window_rank_tracker;
    logic [7:0]  ring [STORE_DEPTH];
    int unsigned width_reg, height_reg, radius_reg, frac_reg;
    int unsigned in_col, in_row, out_col, out_row;
    bit          in_done;
    out_item_t   expected_ranks [$];
    int          mismatches;

    function new();
      foreach (ring[i]) ring[i] = 8'd0;
      width_reg  = 1024;
      height_reg = 1024;
      radius_reg = 1;
      frac_reg   = 32768;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 0;
    endfunction

    function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_w();
      return clampu(width_reg, 1, MAX_WIDTH);
    endfunction

    function int unsigned eff_h();
      return clampu(height_reg, 1, MAX_HEIGHT);
    endfunction

    function int unsigned eff_r();
      return clampu(radius_reg, 1, MAX_RADIUS);
    endfunction

    function void configure(logic [7:0] idx, logic [16:0] val);
      case (idx)
        CFG_FRAME_WIDTH: width_reg = val[10:0];
        CFG_FRAME_HEIGHT: height_reg = val[12:0];
        CFG_WINDOW_RADIUS: radius_reg = val[3:0];
        CFG_RANK_FRACTION: frac_reg = val;
        default: return;
      endcase
      restart();
    endfunction

    function bit window_complete();
      int unsigned nr, nc;
      if (in_done) return 1;
      nr = out_row + eff_r();
      if (nr > eff_h() - 1) nr = eff_h() - 1;
      nc = out_col + eff_r();
      if (nc > eff_w() - 1) nc = eff_w() - 1;
      return (in_row > nr) || (in_row == nr && in_col > nc);
    endfunction

    // rank statistic of the clipped window at the output position
    function out_item_t rank_at_output();
      int unsigned hist [256];
      int unsigned w, h, r, r0, r1, c0, c1, cnt, sum, v;
      longint unsigned thr;
      out_item_t res;
      w = eff_w(); h = eff_h(); r = eff_r();
      r0 = (out_row > r) ? out_row - r : 0;
      c0 = (out_col > r) ? out_col - r : 0;
      r1 = out_row + r; if (r1 > h - 1) r1 = h - 1;
      c1 = out_col + r; if (c1 > w - 1) c1 = w - 1;
      foreach (hist[i]) hist[i] = 0;
      for (int unsigned rr = r0; rr <= r1; rr++)
        for (int unsigned cc = c0; cc <= c1; cc++)
          hist[ring[(rr * w + cc) % STORE_DEPTH]]++;
      cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
      thr = (longint'((frac_reg > 65536) ? 65536 : frac_reg) * cnt) >> 16;
      v = 0;
      if (thr != 0) begin
        sum = 0;
        for (v = 0; v < 255; v++) begin
          sum += hist[v];
          if (sum >= thr) break;
        end
      end
      res.pixel_out = v[7:0];
      res.frame_end = (out_row == h - 1 && out_col == w - 1);
      if (res.frame_end) begin
        restart();
      end else if (out_col + 1 >= w) begin
        out_col = 0; out_row++;
      end else begin
        out_col++;
      end
      return res;
    endfunction

    function void note_input(in_item_t it);
      int unsigned w, h;
      w = eff_w(); h = eff_h();
      if (it.op == OP_PUSH) begin
        if (in_done) return;
        ring[(in_row * w + in_col) % STORE_DEPTH] = it.pixel_in;
        if (in_col + 1 >= w) begin
          in_col = 0;
          if (in_row + 1 >= h) begin
            in_row = 0; in_done = 1;
          end else begin
            in_row++;
          end
        end else begin
          in_col++;
        end
      end
      if (window_complete()) expected_ranks.push_back(rank_at_output());
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: pixel %0d end %0b",
                                       got.pixel_out, got.frame_end);
        return;
      end
      exp_item = expected_ranks.pop_front();
      if (got.pixel_out !== exp_item.pixel_out || got.frame_end !== exp_item.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected pixel %0d end %0b, got pixel %0d end %0b",
                   exp_item.pixel_out, exp_item.frame_end, got.pixel_out, got.frame_end);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [16:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o, out_ready_i;
  out_item_t   out_data_o;

  window_rank_tracker tracker;
  int send_idle_pct, recv_idle_pct;
  int rand_items;
  int cycle_count;
  bit pressure_done;

  histogram_rank_filter_2d_core i_dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(out_data_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("histogram_rank_filter_2d_core test failed");
      $finish;
    end
  end

  task automatic send_beat(logic op, logic [7:0] pix);
    in_item_t it;
    int gap;
    it.op = op;
    it.pixel_in = pix;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_input(it);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.configure(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the sender until every result is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.expected_ranks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r, int unsigned q);
    settle();
    write_reg(CFG_FRAME_WIDTH,   {6'($urandom_range(0, 63)), w[10:0]});
    write_reg(CFG_FRAME_HEIGHT,  {4'($urandom_range(0, 15)), h[12:0]});
    write_reg(CFG_WINDOW_RADIUS, {13'($urandom_range(0, 8191)), r[3:0]});
    write_reg(CFG_RANK_FRACTION, q[16:0]);
  endtask

  // one frame with random content, stray drains, and pushes after the last pixel
  task automatic run_frame(int unsigned npix, bit finish);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(OP_DRAIN, 8'($urandom_range(0, 255)));
        rand_items++;
      end
      if (!pressure_done && i == npix / 2 && npix > 8) begin
        settle();
        pressure_done = 1;
      end
      send_beat(OP_PUSH, 8'($urandom_range(0, 255)));
      rand_items++;
    end
    while (finish && tracker.in_done) begin
      send_beat(($urandom_range(0, 9) == 0) ? OP_PUSH : OP_DRAIN,
                8'($urandom_range(0, 255)));
      rand_items++;
    end
  endtask

  initial begin
    int unsigned w, h, r, q, npix;
    tracker       = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 8'd0;
    cfg_data_i    = 17'd0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    cycle_count   = 0;
    rand_items    = 0;
    pressure_done = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: a few pushes and a drain with nothing ready
    send_beat(OP_PUSH, 8'd0);
    send_beat(OP_PUSH, 8'd255);
    send_beat(OP_DRAIN, 8'd0);

    // single pixel frame with zero threshold
    set_frame(1, 1, 1, 0);
    send_beat(OP_PUSH, 8'd255);
    send_beat(OP_PUSH, 8'd128);

    // radius below range, fraction above full scale, push after last pixel
    set_frame(3, 2, 0, 17'h1FFFF);
    send_beat(OP_PUSH, 8'd255); send_beat(OP_PUSH, 8'd0);   send_beat(OP_PUSH, 8'd17);
    send_beat(OP_PUSH, 8'd240); send_beat(OP_PUSH, 8'd1);   send_beat(OP_PUSH, 8'd254);
    send_beat(OP_PUSH, 8'd99);
    while (tracker.in_done) send_beat(OP_DRAIN, 8'd0);

    // full scale fraction
    set_frame(2, 2, 1, 65536);
    send_beat(OP_PUSH, 8'd10); send_beat(OP_PUSH, 8'd200);
    send_beat(OP_PUSH, 8'd30); send_beat(OP_PUSH, 8'd77);
    while (tracker.in_done) send_beat(OP_DRAIN, 8'd0);

    // size registers above range are clamped, writes to other indexes leave the frame running
    set_frame(2047, 8191, 15, 65535);
    send_beat(OP_PUSH, 8'd5); send_beat(OP_PUSH, 8'd6);
    settle();
    write_reg(8'd4, 17'd3);
    write_reg(8'd255, 17'h1FFFF);
    send_beat(OP_PUSH, 8'd7); send_beat(OP_DRAIN, 8'd0);

    // size registers of zero are clamped to one
    set_frame(0, 0, 2, 32768);
    send_beat(OP_PUSH, 8'd42);

    // random frames in three idling regimes
    while (rand_items < 500) begin
      if (rand_items < 170) begin
        send_idle_pct = 13; recv_idle_pct = 72;
      end else if (rand_items < 340) begin
        send_idle_pct = 72; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(8, 16); h = $urandom_range(4, 8); r = 15;
      end else begin
        w = $urandom_range(1, 12); h = $urandom_range(1, 8); r = $urandom_range(1, 4);
      end
      case ($urandom_range(0, 5))
        0: q = 0;
        1: q = 65536;
        2: q = $urandom_range(65537, 131071);
        default: q = $urandom_range(0, 65535);
      endcase
      set_frame(w, h, r, q);
      npix = w * h;
      if ($urandom_range(0, 7) == 0) run_frame($urandom_range(0, npix - 1), 0);
      else run_frame(npix, 1);
    end

    // wait for the tail, then let the block go quiet
    in_valid_i <= 1'b0;
    while (tracker.expected_ranks.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_ranks.size() == 0) begin
      $display("histogram_rank_filter_2d_core test passed");
    end else begin
      $display("histogram_rank_filter_2d_core test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hr2d_pkg.sv
rtl/hr2d_ram.sv
rtl/hr2d_datapath.sv
rtl/hr2d_ctrl.sv
rtl/histogram_rank_filter_2d_core.sv
test/tb_histogram_rank_filter_2d_core.sv
